>>> hw/rtl/ipl4_pkg.sv
// ipl4_pkg: shared types and constants for the IPv6 L4 port extractor.
// No dependencies; imported by all ipl4 modules.
package ipl4_pkg;

    localparam int MAX_PACKET_BYTES = 16384;
    localparam int OFF_W            = 16;

    // next-header codes
    localparam logic [7:0] NH_HOP   = 8'd0;
    localparam logic [7:0] NH_TCP   = 8'd6;
    localparam logic [7:0] NH_UDP   = 8'd17;
    localparam logic [7:0] NH_ROUTE = 8'd43;
    localparam logic [7:0] NH_AH    = 8'd51;
    localparam logic [7:0] NH_DEST  = 8'd60;

    // fixed-header offsets
    localparam logic [OFF_W-1:0] OFF_NEXT_HDR  = 16'd6;
    localparam logic [OFF_W-1:0] OFF_FIXED_END = 16'd39;
    localparam logic [OFF_W-1:0] FIXED_HDR_LEN = 16'd40;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_TCP       = 2'd0;
    localparam status_t STATUS_UDP       = 2'd1;
    localparam status_t STATUS_TRUNC     = 2'd2;
    localparam status_t STATUS_UNSUPPORT = 2'd3;

    typedef struct packed {
        logic [15:0] src_port;
        logic [15:0] dst_port;
        status_t     status;
    } result_t;

endpackage

>>> hw/rtl/ipl4_parse.sv
// ipl4_parse: header-chain walk state and per-byte next-state / result logic.
// Depends on ipl4_pkg.
module ipl4_parse
    import ipl4_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,       // one byte moves out of the input register
    input  logic [7:0]    data_byte,
    input  logic          last,
    output result_t       res         // valid when step && last
);

    typedef enum logic [1:0] {
        PH_FIXED,
        PH_HDR,
        PH_LEN8,
        PH_LEN4
    } phase_t;

    phase_t             phase_reg, phase_adv, phase_next;
    logic [OFF_W-1:0]   off_reg, off_adv, off_next;
    logic [OFF_W-1:0]   hs_reg, hs_adv, hs_next;
    logic [7:0]         nh_reg, nh_adv, nh_next;
    logic [15:0]        src_reg, src_adv, src_next;
    logic [15:0]        dst_reg, dst_adv, dst_next;

    logic               off_full;
    logic [OFF_W-1:0]   rel;
    logic [11:0]        ext_len;
    logic [OFF_W:0]     hs_sum;
    logic [OFF_W-1:0]   rem;
    logic               nh_ext8;
    logic               nh_ext;

    assign off_full = (off_reg >= OFF_W'(MAX_PACKET_BYTES));
    assign rel      = off_reg - hs_reg;
    assign nh_ext8  = (nh_reg == NH_HOP) || (nh_reg == NH_ROUTE) || (nh_reg == NH_DEST);
    assign ext_len  = ((phase_reg == PH_LEN8) ? {1'b0, data_byte, 3'b000}
                                              : {2'b00, data_byte, 2'b00}) + 12'd8;
    assign hs_sum   = {1'b0, hs_reg} + (OFF_W+1)'(ext_len);

    // walk one byte
    always_comb
    begin
        phase_adv = phase_reg;
        off_adv   = off_reg;
        hs_adv    = hs_reg;
        nh_adv    = nh_reg;
        src_adv   = src_reg;
        dst_adv   = dst_reg;
        if (step && !off_full)
        begin
            off_adv = off_reg + 16'd1;
            unique case (phase_reg)
                PH_FIXED:
                begin
                    if (off_reg == OFF_NEXT_HDR)
                        nh_adv = data_byte;
                    if (off_reg == OFF_FIXED_END)
                        phase_adv = PH_HDR;
                end
                PH_HDR:
                begin
                    if (off_reg >= hs_reg)
                    begin
                        if ((nh_reg == NH_TCP) || (nh_reg == NH_UDP))
                        begin
                            unique case (rel)
                                16'd0:   src_adv[15:8] = data_byte;
                                16'd1:   src_adv[7:0]  = data_byte;
                                16'd2:   dst_adv[15:8] = data_byte;
                                16'd3:   dst_adv[7:0]  = data_byte;
                                default: ;
                            endcase
                        end
                        else if ((rel == 16'd0) && (nh_ext8 || (nh_reg == NH_AH)))
                        begin
                            phase_adv = nh_ext8 ? PH_LEN8 : PH_LEN4;
                            nh_adv    = data_byte;
                        end
                    end
                end
                PH_LEN8, PH_LEN4:
                begin
                    hs_adv    = hs_sum[OFF_W] ? {OFF_W{1'b1}} : hs_sum[OFF_W-1:0];
                    phase_adv = PH_HDR;
                end
            endcase
        end
    end

    // judge the packet on the state after this byte
    assign rem    = off_adv - hs_adv;
    assign nh_ext = (nh_adv == NH_HOP) || (nh_adv == NH_ROUTE) ||
                    (nh_adv == NH_DEST) || (nh_adv == NH_AH);

    always_comb
    begin
        res = '0;
        if ((phase_adv != PH_HDR) || (off_adv <= hs_adv))
            res.status = STATUS_TRUNC;
        else if (nh_adv == NH_TCP)
            res.status = (rem >= 16'd20) ? STATUS_TCP : STATUS_TRUNC;
        else if (nh_adv == NH_UDP)
            res.status = (rem >= 16'd8) ? STATUS_UDP : STATUS_TRUNC;
        else if (nh_ext)
            res.status = STATUS_TRUNC;
        else
            res.status = STATUS_UNSUPPORT;
        if ((res.status == STATUS_TCP) || (res.status == STATUS_UDP))
        begin
            res.src_port = src_adv;
            res.dst_port = dst_adv;
        end
    end

    // back to reset values after the last byte
    always_comb
    begin
        if (step && last)
        begin
            phase_next = PH_FIXED;
            off_next   = '0;
            hs_next    = FIXED_HDR_LEN;
            nh_next    = '0;
            src_next   = '0;
            dst_next   = '0;
        end
        else
        begin
            phase_next = phase_adv;
            off_next   = off_adv;
            hs_next    = hs_adv;
            nh_next    = nh_adv;
            src_next   = src_adv;
            dst_next   = dst_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIXED;
            off_reg   <= '0;
            hs_reg    <= FIXED_HDR_LEN;
            nh_reg    <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            hs_reg    <= hs_next;
            nh_reg    <= nh_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
        end
    end

endmodule

>>> hw/rtl/ipl4_result_reg.sv
// ipl4_result_reg: output register of the result channel.
// Depends on ipl4_pkg.
module ipl4_result_reg
    import ipl4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     res,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] src_port,
    output logic [15:0] dst_port,
    output logic [1:0]  status,
    output logic        end_of_result
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    // load only happens when the register is empty or draining
    assign valid_next = load | (valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid     = valid_reg;
    assign src_port      = res_reg.src_port;
    assign dst_port      = res_reg.dst_port;
    assign status        = res_reg.status;
    assign end_of_result = 1'b1;

endmodule

>>> hw/rtl/ipv6_l4_port_extractor.sv
// ipv6_l4_port_extractor: top level, input register plus parser and result register.
// Depends on ipl4_pkg, ipl4_parse, ipl4_result_reg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | sink      | in_valid / in_stall   | data_byte[7:0], last
//  out     | source    | out_valid / out_stall | src_port, dst_port, status, end_of_result
//
// One byte per cycle sustained while in_stall is low. A byte waits in the
// input register, then the parser updates its walk state; a last byte writes
// the result register as it leaves the input register, raising out_valid.
// Reset (rst_n, async, active low) clears the walk state and both valid bits.
// Non-last bytes keep flowing while a result waits; only a last byte held
// behind a stalled, full result register raises in_stall.
module ipv6_l4_port_extractor
    import ipl4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] src_port,
    output logic [15:0] dst_port,
    output logic [1:0]  status,
    output logic        end_of_result
);

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       s1_adv;
    logic       in_take;
    result_t    res;

    // a last byte needs room in the result register
    assign in_stall = s1_valid_reg & s1_last_reg & out_valid & out_stall;
    assign s1_adv   = s1_valid_reg & ~in_stall;
    assign in_take  = in_valid & ~in_stall;

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last;
        end
    end

    ipl4_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_adv),
        .data_byte (s1_byte_reg),
        .last      (s1_last_reg),
        .res       (res)
    );

    ipl4_result_reg u_result
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (s1_adv & s1_last_reg),
        .res           (res),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .src_port      (src_port),
        .dst_port      (dst_port),
        .status        (status),
        .end_of_result (end_of_result)
    );

endmodule
